FILE: sv/equivalence_class_builder_assert.svh
// Assertion macros for the equivalence class builder.
// Used by the port checker; no other dependencies.
`ifndef EQUIVALENCE_CLASS_BUILDER_ASSERT_SVH
`define EQUIVALENCE_CLASS_BUILDER_ASSERT_SVH

// same-cycle implication, reset masks the check
`define ECB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ecb assertion failed");

// next-cycle implication
`define ECB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ecb assertion failed");

`endif

FILE: sv/ecb_pkg.sv
// Shared types and constants of the equivalence class builder.
// Used by the cell and the top level; no dependencies.
package ecb_pkg;

	localparam int IDX_W   = 5;   // element index width
	localparam int SIZE_W  = 6;   // set size register width
	localparam int ROW_CAP = 32;  // widest neighbor row

	typedef logic [IDX_W-1:0]  elem_t;
	typedef logic [SIZE_W-1:0] size_t;

	localparam logic REQ_PAIR    = 1'b0;
	localparam logic REQ_COMPUTE = 1'b1;

	// control broadcast to every cell
	typedef struct packed {
		logic  pair_we;
		elem_t elem_a;
		elem_t elem_b;
		logic  clr_vis;
		logic  claim;
		logic  shift;
		elem_t label;
	} cell_ctl_t;

endpackage

FILE: sv/equivalence_class_builder.sv
// Top level of the equivalence class builder: sequencer plus a chain of
// element cells. Depends on ecb_pkg and ecb_cell.
//
//  port group   dir  contents
//  s_*          in   tuser: req_type; tdata: first_elem, second_elem
//  m_*          out  tdata: element, class_rep; tlast: last
//  cfg_*        in   set_size write
//
// A compute item scans roots one per cycle, pausing for a sweep at each
// unvisited root; such a root sends a reach vector through the NC-stage cell
// chain, pass after pass, until a pass adds nothing. Then n results follow,
// subject to output stalls. Reset clears all relations. s_tready is low from a
// compute item until its last result is taken.
module equivalence_class_builder #(
	parameter int MAX_ELEMS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [4:0] first_elem, [9:5] second_elem
	input  logic        s_tuser,   // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [4:0] element, [9:5] class_rep
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata  // set_size
);
	import ecb_pkg::*;

	localparam int NC = (MAX_ELEMS < ROW_CAP) ? MAX_ELEMS : ROW_CAP;
	localparam int IW = (NC > 1) ? $clog2(NC) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SWEEP,
		ST_EMIT
	} state_t;

	state_t        state_q;
	size_t         set_size_q;
	size_t         root_q;
	size_t         emit_q;
	logic [NC-1:0] inj_q;

	size_t         n_eff;
	logic [NC-1:0] keep;
	elem_t         elem_a;
	elem_t         elem_b;
	logic          in_acc;
	logic          out_acc;
	logic          pair_ok;
	logic          inject;
	logic [NC-1:0] inj_vec;
	logic          done_pass;
	logic          last_res;
	cell_ctl_t     ctl;

	logic [NC-1:0] vec   [NC+1];
	logic          vld   [NC+1];
	elem_t         rep   [NC+1];
	logic [NC-1:0] vis;

	assign n_eff = (set_size_q == '0) ? size_t'(1) :
		((set_size_q > size_t'(NC)) ? size_t'(NC) : set_size_q);
	assign keep  = (NC'(1) << n_eff) - NC'(1);

	assign elem_a  = s_tdata[4:0];
	assign elem_b  = s_tdata[9:5];
	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign pair_ok = ({1'b0, elem_a} < n_eff) && ({1'b0, elem_b} < n_eff);

	// a pass is done when the vector leaving the chain gained nothing
	assign done_pass = (state_q == ST_SWEEP) && vld[NC] && (vec[NC] == inj_q);
	assign last_res  = (emit_q + size_t'(1)) == n_eff;

	always_comb begin
		inject  = 1'b0;
		inj_vec = vec[NC];
		case (state_q)
			ST_SCAN: begin
				inj_vec = NC'(1) << root_q;
				inject  = (root_q != n_eff) && !vis[root_q[IW-1:0]];
			end
			ST_SWEEP: begin
				inject = vld[NC] && !done_pass;
			end
			default: begin
				inject = 1'b0;
			end
		endcase
	end

	always_comb begin
		ctl.pair_we = in_acc && (s_tuser == REQ_PAIR) && pair_ok;
		ctl.elem_a  = elem_a;
		ctl.elem_b  = elem_b;
		ctl.clr_vis = in_acc && (s_tuser == REQ_COMPUTE);
		ctl.claim   = done_pass;
		ctl.shift   = out_acc;
		ctl.label   = root_q[IDX_W-1:0];
	end

	assign vec[0] = inj_vec;
	assign vld[0] = inject;
	assign rep[NC] = '0;

	for (genvar k = 0; k < NC; k++) begin : g_cell
		ecb_cell #(
			.NC (NC),
			.IDX(k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.keep     (keep),
			.claim_vec(vec[NC]),
			.vec_in   (vec[k]),
			.vld_in   (vld[k]),
			.vec_out  (vec[k+1]),
			.vld_out  (vld[k+1]),
			.rep_in   (rep[k+1]),
			.rep_out  (rep[k]),
			.vis_out  (vis[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			set_size_q <= size_t'(ROW_CAP);
			root_q     <= '0;
			emit_q     <= '0;
			inj_q      <= '0;
		end else begin
			if (cfg_we) begin
				set_size_q <= cfg_wdata;
			end
			if (inject) begin
				inj_q <= inj_vec;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_tuser == REQ_COMPUTE)) begin
						root_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (root_q == n_eff) begin
						emit_q  <= '0;
						state_q <= ST_EMIT;
					end else if (inject) begin
						state_q <= ST_SWEEP;
					end else begin
						root_q <= root_q + size_t'(1);
					end
				end
				ST_SWEEP: begin
					if (done_pass) begin
						root_q  <= root_q + size_t'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						if (last_res) begin
							state_q <= ST_IDLE;
						end else begin
							emit_q <= emit_q + size_t'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata  = {6'b0, rep[0], emit_q[IDX_W-1:0]};
	assign m_tlast  = last_res;

endmodule

FILE: sv/ecb_cell.sv
// One element cell: neighbor row, visited flag, class label and one stage of
// the reach-vector chain. Depends on ecb_pkg.
module ecb_cell #(
	parameter int NC  = 32,
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ecb_pkg::cell_ctl_t ctl,
	input  logic [NC-1:0]     keep,
	input  logic [NC-1:0]     claim_vec,
	input  logic [NC-1:0]     vec_in,
	input  logic              vld_in,
	output logic [NC-1:0]     vec_out,
	output logic              vld_out,
	input  ecb_pkg::elem_t    rep_in,
	output ecb_pkg::elem_t    rep_out,
	output logic              vis_out
);
	import ecb_pkg::*;

	localparam elem_t MY_IDX = elem_t'(IDX);

	logic [NC-1:0] row_q;
	logic          vis_q;
	elem_t         rep_q;
	logic [NC-1:0] vec_s1;
	logic          vld_s1;
	logic [NC-1:0] row_set;
	logic [NC-1:0] vec_nxt;
	logic          mine;

	always_comb begin
		row_set = '0;
		if (ctl.elem_a == MY_IDX) begin
			row_set = row_set | (NC'(1) << ctl.elem_b);
		end
		if (ctl.elem_b == MY_IDX) begin
			row_set = row_set | (NC'(1) << ctl.elem_a);
		end
	end

	// a reached element adds all its in-set neighbors
	assign vec_nxt = vec_in[IDX] ? (vec_in | (row_q & keep)) : vec_in;
	assign mine    = ctl.claim && claim_vec[IDX];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			vis_q  <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			if (ctl.pair_we) begin
				row_q <= row_q | row_set;
			end
			if (ctl.clr_vis) begin
				vis_q <= 1'b0;
			end else if (mine) begin
				vis_q <= 1'b1;
			end
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1 <= vec_nxt;
		if (mine) begin
			rep_q <= ctl.label;
		end else if (ctl.shift) begin
			rep_q <= rep_in;
		end
	end

	assign vec_out = vec_s1;
	assign vld_out = vld_s1;
	assign rep_out = rep_q;
	assign vis_out = vis_q;

endmodule

FILE: sv/ecb_checker.sv
// Port-level checker for the equivalence class builder, bound to the top.
// Depends on equivalence_class_builder_assert.svh.
module ecb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);
`include "equivalence_class_builder_assert.svh"

	// no new item is taken while results are being delivered
	`ECB_ASSERT_IMPL(a_no_overlap, clk, arst_n, m_tvalid, !s_tready)
	// a compute item closes the input until its results are out
	`ECB_ASSERT_NEXT(a_compute_busy, clk, arst_n, s_tvalid && s_tready && s_tuser, !s_tready)
	// results of one compute come back to back until the last one
	`ECB_ASSERT_NEXT(a_burst, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid)
	// the last result ends the burst and reopens the input
	`ECB_ASSERT_NEXT(a_end, clk, arst_n, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready)
	// stalled result holds
	`ECB_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind equivalence_class_builder ecb_checker u_ecb_checker (.*);
